>>> rtl/cldw_pkg.sv
// Shared types and constants for the character display write sequencer.
// No dependencies; imported by every module of the block.
package cldw_pkg;

  // Request word accepted on the input channel.
  typedef struct packed {
    logic        action;
    logic [7:0]  row;
    logic [5:0]  column;
    logic [7:0]  char_code;
    logic [15:0] number;
    logic [2:0]  digit_count;
  } cldw_in_t;

  // One bus write delivered on the result channel.
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } cldw_out_t;

  // Request modes.
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_NUM  = 1'b1;

  // Register select values.
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Display command and character constants.
  localparam logic [7:0] LCD_SET_ADDR  = 8'h80;
  localparam logic [7:0] LCD_LINE2_OFS = 8'h40;
  localparam logic [7:0] LCD_FIRST_ROW = 8'h01;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;

  // Default upper limit on the number of digits shown.
  localparam int DEFAULT_MAX_DIGITS = 5;

  // Reciprocal of ten for a 16-bit dividend: q = (v * 52429) >> 19 is exact.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam logic [3:0]  RADIX       = 4'd10;

endpackage

>>> rtl/cldw_div10.sv
// Divide-by-ten unit: quotient and remainder of a 16-bit value.
// Depends on cldw_pkg for the reciprocal constants.
module cldw_div10
  import cldw_pkg::*;
(
  input  logic [15:0] dividend,
  output logic [15:0] quotient,
  output logic [3:0]  remainder
);

  logic [31:0] prod;
  logic [15:0] q_times_ten;
  logic [15:0] diff;

  // Multiply by the scaled reciprocal and keep the integer part.
  assign prod     = dividend * DIV10_MUL;
  assign quotient = 16'(prod >> DIV10_SHIFT);

  // Remainder is what the quotient times ten leaves; it is always below ten.
  assign q_times_ten = (quotient << 3) + (quotient << 1);
  assign diff        = dividend - q_times_ten;
  assign remainder   = diff[3:0];

endmodule

>>> rtl/char_lcd_decimal_writer.sv
// Character display write sequencer: one request becomes a set-address command
// followed by a character byte or a run of decimal digits, one bus word each.
// Character mode: 2 output words, one per cycle unless the output stalls.
// Number mode with n digits: the shared divide-by-ten unit works out the digits first,
// then n+1 output words at one per cycle unless stalled; the next request is taken after that.
// Reset (rst_n low, synchronous) returns to idle and drops any pending word.
module char_lcd_decimal_writer
  import cldw_pkg::*;
#(
  parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cldw_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cldw_out_t out_data
);

  // The digit count field is three bits wide, so at most seven digits are held.
  localparam int DIG_DEPTH = (MAX_DIGITS < 7) ? MAX_DIGITS : 7;
  localparam int CNT_W     = $clog2(DIG_DEPTH + 1);
  localparam int IDX_W     = (DIG_DEPTH > 1) ? $clog2(DIG_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_ADDR,
    S_CHAR,
    S_DIGIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     val_r, val_nxt;
  logic [CNT_W-1:0] ndig_r, ndig_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [7:0]      addr_r, addr_nxt;
  logic [7:0]      char_r, char_nxt;
  logic            mode_r, mode_nxt;
  logic [3:0]      dig_r [DIG_DEPTH];
  logic            out_valid_r, out_valid_nxt;
  cldw_out_t       out_data_r, out_data_nxt;

  logic [15:0]      quo;
  logic [3:0]       rem;
  logic             slot_free;
  logic [7:0]       base;
  logic [CNT_W-1:0] cnt_clamped;
  logic [CNT_W-1:0] k_dec;
  logic             dig_we;

  // Shared divide-by-ten unit, one digit per cycle, least significant first.
  cldw_div10 u_div10 (
    .dividend  (val_r),
    .quotient  (quo),
    .remainder (rem)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;
  assign k_dec     = k_r - CNT_W'(1);

  // Address base for the selected line and the clamped digit count.
  always_comb begin
    base = (in_data.row == LCD_FIRST_ROW) ? LCD_SET_ADDR : (LCD_SET_ADDR + LCD_LINE2_OFS);
    if (int'(in_data.digit_count) > DIG_DEPTH) begin
      cnt_clamped = CNT_W'(DIG_DEPTH);
    end else begin
      cnt_clamped = in_data.digit_count[CNT_W-1:0];
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    ndig_nxt      = ndig_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    char_nxt      = char_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    dig_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt = base + {2'b00, in_data.column} - 8'd1;
          char_nxt = in_data.char_code;
          mode_nxt = in_data.action;
          val_nxt  = in_data.number;
          ndig_nxt = cnt_clamped;
          k_nxt    = '0;
          if (in_data.action == ACT_NUM && cnt_clamped != '0) begin
            state_nxt = S_CONV;
          end else begin
            state_nxt = S_ADDR;
          end
        end
      end
      S_CONV: begin
        dig_we  = 1'b1;
        val_nxt = quo;
        k_nxt   = k_r + CNT_W'(1);
        if (k_r == ndig_r - CNT_W'(1)) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.is_data = RS_CMD;
          out_data_nxt.bus_byte = addr_r;
          if (mode_r == ACT_CHAR) begin
            out_data_nxt.last = 1'b0;
            state_nxt         = S_CHAR;
          end else if (ndig_r == '0) begin
            out_data_nxt.last = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            out_data_nxt.last = 1'b0;
            k_nxt             = ndig_r;
            state_nxt         = S_DIGIT;
          end
        end
      end
      S_CHAR: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.is_data  = RS_DATA;
          out_data_nxt.bus_byte = char_r;
          out_data_nxt.last     = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.is_data  = RS_DATA;
          out_data_nxt.bus_byte = ASCII_ZERO + {4'b0000, dig_r[k_dec[IDX_W-1:0]]};
          out_data_nxt.last     = (k_r == CNT_W'(1));
          k_nxt                 = k_dec;
          if (k_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    ndig_r     <= ndig_nxt;
    k_r        <= k_nxt;
    addr_r     <= addr_nxt;
    char_r     <= char_nxt;
    mode_r     <= mode_nxt;
    out_data_r <= out_data_nxt;
  end

  // Digit store, filled least significant digit first.
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_r[k_r[IDX_W-1:0]] <= rem;
    end
  end

endmodule

>>> tb/char_lcd_decimal_writer_tb.sv
// Self-checking testbench for the character display write sequencer.
// Depends on cldw_pkg and char_lcd_decimal_writer; predicts every bus word in-bench.
module char_lcd_decimal_writer_tb
  import cldw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGIT_LIMIT  = DEFAULT_MAX_DIGITS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  cldw_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  cldw_out_t out_data;

  // Bus words still owed by the block, oldest first.
  cldw_out_t pending_writes[$];

  bit idle_on = 1'b1;
  int mismatches;
  int n_requests;
  int n_char_requests;
  int n_num_requests;
  int n_words_seen;

  char_lcd_decimal_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d words outstanding", CYCLE_LIMIT,
             pending_writes.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Prints one line per mismatch and keeps the tally.
  task automatic report_mismatch(input string what, input int got, input int want);
    begin
      mismatches++;
      $display("[%0t] mismatch on %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
    end
  endtask

  // Works out the bus words one request should produce and queues them.
  task automatic predict_writes(input cldw_in_t req);
    logic [7:0] line_base;
    cldw_out_t  w;
    int         digits;
    int         scale;
    begin
      line_base = (req.row == LCD_FIRST_ROW) ? LCD_SET_ADDR : (LCD_SET_ADDR | LCD_LINE2_OFS);
      digits = (req.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(req.digit_count);

      // The address command comes first; it wraps within one byte.
      w.is_data  = RS_CMD;
      w.bus_byte = line_base + {2'b00, req.column} - 8'd1;
      w.last     = (req.action == ACT_NUM) && (digits == 0);
      pending_writes.push_back(w);

      if (req.action == ACT_CHAR) begin
        w.is_data  = RS_DATA;
        w.bus_byte = req.char_code;
        w.last     = 1'b1;
        pending_writes.push_back(w);
      end else begin
        // Digits go out most significant first, leading zeros kept.
        for (int pos = digits; pos > 0; pos--) begin
          scale = 1;
          for (int k = 1; k < pos; k++) scale *= 10;
          w.is_data  = RS_DATA;
          w.bus_byte = ASCII_ZERO + 8'((int'(req.number) / scale) % 10);
          w.last     = (pos == 1);
          pending_writes.push_back(w);
        end
      end
    end
  endtask

  // Offers one request, holding it steady until the block takes it.
  task automatic send_request(input cldw_in_t req);
    int gap;
    begin
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= req;
      do @(posedge clk); while (!in_ready);
      predict_writes(req);
      n_requests++;
      if (req.action == ACT_CHAR) n_char_requests++;
      else n_num_requests++;
    end
  endtask

  function automatic cldw_in_t make_request(input logic action, input logic [7:0] row,
                                            input logic [5:0] column,
                                            input logic [7:0] char_code,
                                            input logic [15:0] number,
                                            input logic [2:0] digit_count);
    cldw_in_t r;
    r.action      = action;
    r.row         = row;
    r.column      = column;
    r.char_code   = char_code;
    r.number      = number;
    r.digit_count = digit_count;
    return r;
  endfunction

  // Mostly plausible requests; roughly one in seven is raw noise over every bit.
  function automatic cldw_in_t random_request();
    cldw_in_t r;
    r = make_request($urandom_range(0, 1) ? ACT_NUM : ACT_CHAR, 8'($urandom_range(1, 2)),
                     6'($urandom_range(1, 40)), 8'($urandom), 16'($urandom),
                     3'($urandom_range(0, DIGIT_LIMIT)));
    if ($urandom_range(0, 3) == 0) r.row = 8'($urandom);
    if ($urandom_range(0, 2) == 0) r.number = 16'($urandom_range(0, 999));
    if ($urandom_range(0, 6) == 0)
      r = cldw_in_t'($bits(cldw_in_t)'({$urandom, $urandom}));
    if ($urandom_range(0, 6) == 0) begin
      r.row         = 8'($urandom);
      r.column      = 6'($urandom);
      r.digit_count = 3'($urandom);
    end
    return r;
  endfunction

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Each accepted word is checked against the oldest prediction.
  always @(posedge clk) begin
    cldw_out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_words_seen++;
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected word", int'(out_data), 0);
      end else begin
        want = pending_writes.pop_front();
        if (out_data.is_data !== want.is_data)
          report_mismatch("is_data", int'(out_data.is_data), int'(want.is_data));
        if (out_data.bus_byte !== want.bus_byte)
          report_mismatch("bus_byte", int'(out_data.bus_byte), int'(want.bus_byte));
        if (out_data.last !== want.last)
          report_mismatch("last", int'(out_data.last), int'(want.last));
      end
    end
  end

  // Character mode: extremes of the character byte, unused fields filled with junk.
  task automatic test_char_mode();
    begin
      send_request(make_request(ACT_CHAR, 8'd1, 6'd1, 8'h00, 16'hFFFF, 3'd7));
      send_request(make_request(ACT_CHAR, 8'd2, 6'd40, 8'hFF, 16'h0000, 3'd0));
      send_request(make_request(ACT_CHAR, 8'd0, 6'd16, 8'h41, 16'hA5A5, 3'd3));
    end
  endtask

  // Address byte wrap for column zero and columns past the line end, odd rows.
  task automatic test_address_wrap();
    begin
      send_request(make_request(ACT_CHAR, 8'd1, 6'd0, 8'h5A, 16'd0, 3'd0));
      send_request(make_request(ACT_CHAR, 8'd255, 6'd63, 8'h7E, 16'd0, 3'd0));
      send_request(make_request(ACT_NUM, 8'd2, 6'd0, 8'h00, 16'd9, 3'd1));
      send_request(make_request(ACT_NUM, 8'd1, 6'd63, 8'hFF, 16'd42, 3'd2));
    end
  endtask

  // Number mode: every digit count including zero and the clamped ones.
  task automatic test_number_mode();
    begin
      for (int n = 0; n < 8; n++)
        send_request(make_request(ACT_NUM, 8'd1, 6'(n + 1), 8'hC3, 16'd12345, 3'(n)));
      send_request(make_request(ACT_NUM, 8'd2, 6'd5, 8'h00, 16'd0, 3'd5));
      send_request(make_request(ACT_NUM, 8'd1, 6'd34, 8'hFF, 16'd65535, 3'd5));
      send_request(make_request(ACT_NUM, 8'd3, 6'd12, 8'h11, 16'd65535, 3'd7));
      send_request(make_request(ACT_NUM, 8'd2, 6'd20, 8'h22, 16'd7, 3'd4));
      send_request(make_request(ACT_NUM, 8'd1, 6'd2, 8'h33, 16'd40960, 3'd3));
    end
  endtask

  // Random requests with both sides idling in bursts.
  task automatic test_random_requests(input int count);
    begin
      for (int i = 0; i < count; i++) send_request(random_request());
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_back_to_back(input int count);
    begin
      idle_on = 1'b0;
      for (int i = 0; i < count; i++) send_request(random_request());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_char_mode();
    test_address_wrap();
    test_number_mode();
    test_random_requests(330);
    test_back_to_back(100);

    // Stop offering requests and let the last words drain.
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0)
      report_mismatch("words never delivered", pending_writes.size(), 0);

    $display("covered %0d requests (%0d character, %0d number) and %0d bus words",
             n_requests, n_char_requests, n_num_requests, n_words_seen);
    $display("address wrap, zero and clamped digit counts, and random idling were exercised");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
